FILE: design/mic_array_delayed_tone_synth_core_defines.svh
// assertion macros for the delayed tone synthesiser
// expects clk and arst_n in the scope of use
`ifndef MIC_ARRAY_DELAYED_TONE_SYNTH_CORE_DEFINES_SVH
`define MIC_ARRAY_DELAYED_TONE_SYNTH_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define MADS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MADS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mads_pkg.sv
// shared types, codes and constants of the delayed tone synthesiser
// no dependencies; the sine quarter wave is built at elaboration
package mads_pkg;

	localparam int COORD_W   = 16;
	localparam int FREQ_W    = 24;
	localparam int TICK_W    = 32;
	localparam int RATE_W    = 18;
	localparam int SPEED_W   = 11;
	localparam int SAMPLE_W  = 16;
	localparam int CMD_W     = 2;
	localparam int SEL_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 18;

	localparam int SQ_IN_W  = 50;
	localparam int SQ_OUT_W = 25;
	localparam int DIV_NW   = 58;
	localparam int DIV_DW   = 18;
	localparam int TRAV_W   = 27;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_MIC    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED = 1'd1;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [FREQ_W-1:0]         freq;
		logic [TICK_W-1:0]         start;
	} src_entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

	typedef logic [14:0] qtab_t [257];

	function automatic qtab_t build_qtab();
		qtab_t t;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] r;
		logic signed [63:0] sum;
		for (int x = 0; x <= 256; x++) begin
			a = (64'(x) * PI_Q30) / 64'd512;
			a2 = (a * a) >> 30;
			term = a;
			sum = signed'(a);
			for (int k = 1; k < 8; k++) begin
				term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k[0]) begin
					sum = sum - signed'(term);
				end else begin
					sum = sum + signed'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			r = (64'(sum) + 64'd16384) >> 15;
			if (r > 64'd32767) begin
				r = 64'd32767;
			end
			t[x] = 15'(r);
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	function automatic logic signed [SAMPLE_W-1:0] sine_value(input logic [9:0] idx);
		logic [7:0] r;
		logic [14:0] v;
		r = idx[7:0];
		v = idx[8] ? QTAB[9'd256 - 9'(r)] : QTAB[9'(r)];
		return idx[9] ? -signed'({1'b0, v}) : signed'({1'b0, v});
	endfunction

endpackage

FILE: design/mads_req_if.sv
// request channel of the delayed tone synthesiser: commands and positions
// depends on mads_pkg for field widths
interface mads_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [mads_pkg::CMD_W-1:0]           cmd;
	logic signed [mads_pkg::COORD_W-1:0]  pos_x;
	logic signed [mads_pkg::COORD_W-1:0]  pos_y;
	logic signed [mads_pkg::COORD_W-1:0]  pos_z;
	logic [mads_pkg::FREQ_W-1:0]          tone_freq;
	logic [mads_pkg::SEL_W-1:0]           mic_select;

	modport source (output valid, cmd, pos_x, pos_y, pos_z, tone_freq, mic_select,
		input ready);
	modport sink (input valid, cmd, pos_x, pos_y, pos_z, tone_freq, mic_select,
		output ready);
endinterface

FILE: design/mads_rsp_if.sv
// response channel of the delayed tone synthesiser: samples and status
// depends on mads_pkg for field widths
interface mads_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mads_pkg::SAMPLE_W-1:0] mic_sample;
	logic [mads_pkg::SEL_W-1:0]           mic_number;
	logic                                 last;
	logic [mads_pkg::STATUS_W-1:0]        status;

	modport source (output valid, mic_sample, mic_number, last, status, input ready);
	modport sink (input valid, mic_sample, mic_number, last, status, output ready);
endinterface

FILE: design/mads_isqrt.sv
// iterative floor square root, two radicand bits per cycle
// depends on mads_pkg for widths and the status struct
module mads_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mads_pkg::SQ_IN_W-1:0]  radicand,
	output logic [mads_pkg::SQ_OUT_W-1:0] root,
	output mads_pkg::iter_stat_t          stat
);
	localparam int OW = mads_pkg::SQ_OUT_W;
	localparam int IW = mads_pkg::SQ_IN_W;
	localparam int CNTW = $clog2(OW);

	logic [IW-1:0]   rad_q;
	logic [OW:0]     rem_q;
	logic [OW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [OW+2:0]   rem_sh;
	logic            fits;

	assign rem_sh = {rem_q, rad_q[IW-1:IW-2]};
	assign fits   = rem_sh >= ((OW+3)'({root_q, 2'b01}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(OW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(OW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[IW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= (OW+1)'(rem_sh - (OW+3)'({root_q, 2'b01}));
				root_q <= {root_q[OW-2:0], 1'b1};
			end else begin
				rem_q  <= (OW+1)'(rem_sh);
				root_q <= {root_q[OW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

FILE: design/mads_divu.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on mads_pkg for widths and the status struct
module mads_divu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mads_pkg::DIV_NW-1:0] numer,
	input  logic [mads_pkg::DIV_DW-1:0] denom,
	output logic [mads_pkg::DIV_NW-1:0] quot,
	output mads_pkg::iter_stat_t        stat
);
	localparam int NW = mads_pkg::DIV_NW;
	localparam int DW = mads_pkg::DIV_DW;
	localparam int CNTW = $clog2(NW);

	logic [NW-1:0]   num_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic            fits;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(NW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift in where numerator bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
		end
	end

	assign quot = num_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

FILE: design/mic_array_delayed_tone_synth_core.sv
// Add scans the slots for a free one; remove scans them for an entry with matching x and y.
// Tick: per microphone, each active source passes through the 25-step root and a 58-step
// division, then, once its sound has arrived, a second one; the average takes one more.
// One transaction at a time; results leave through an output register, so the next
// request is taken while the last result still waits.
// Reset: tick count, microphone positions and source valid bits clear, configuration registers reload.
`include "mic_array_delayed_tone_synth_core_defines.svh"
module mic_array_delayed_tone_synth_core #(
	parameter int NUM_MICS    = 4,
	parameter int MAX_SOURCES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mads_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mads_pkg::CFG_DATA_W-1:0] cfg_data,
	mads_req_if.sink                        req,
	mads_rsp_if.source                      rsp
);
	localparam int MW   = (NUM_MICS > 1) ? $clog2(NUM_MICS) : 1;
	localparam int SW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CW   = $clog2(MAX_SOURCES + 1);
	localparam int SUMW = mads_pkg::SAMPLE_W + CW;
	localparam int CDW  = mads_pkg::COORD_W;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_ADD_SCAN  = 5'd1;
	localparam logic [4:0] S_RM_RD     = 5'd2;
	localparam logic [4:0] S_RM_CHK    = 5'd3;
	localparam logic [4:0] S_MIC_INIT  = 5'd4;
	localparam logic [4:0] S_SRC_RD    = 5'd5;
	localparam logic [4:0] S_SQ        = 5'd6;
	localparam logic [4:0] S_SQRT_GO   = 5'd7;
	localparam logic [4:0] S_SQRT_WAIT = 5'd8;
	localparam logic [4:0] S_MUL1      = 5'd9;
	localparam logic [4:0] S_DIV1_GO   = 5'd10;
	localparam logic [4:0] S_DIV1_WAIT = 5'd11;
	localparam logic [4:0] S_PHASE     = 5'd12;
	localparam logic [4:0] S_MUL2      = 5'd13;
	localparam logic [4:0] S_DIV2_GO   = 5'd14;
	localparam logic [4:0] S_DIV2_WAIT = 5'd15;
	localparam logic [4:0] S_NEXT      = 5'd16;
	localparam logic [4:0] S_AVG_GO    = 5'd17;
	localparam logic [4:0] S_AVG_WAIT  = 5'd18;
	localparam logic [4:0] S_EMIT      = 5'd19;

	// configuration
	logic [mads_pkg::RATE_W-1:0]  rate_q;
	logic [mads_pkg::SPEED_W-1:0] speed_q;
	logic [mads_pkg::RATE_W-1:0]  rate_eff;
	logic [mads_pkg::SPEED_W-1:0] speed_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= 18'd48000;
			speed_q <= 11'd343;
		end else if (cfg_we) begin
			if (cfg_index == mads_pkg::CFG_SAMPLE_RATE) begin
				rate_q <= cfg_data[mads_pkg::RATE_W-1:0];
			end else begin
				speed_q <= cfg_data[mads_pkg::SPEED_W-1:0];
			end
		end
	end

	assign rate_eff  = (rate_q == '0) ? mads_pkg::RATE_W'(1) : rate_q;
	assign speed_eff = (speed_q == '0) ? mads_pkg::SPEED_W'(1) : speed_q;

	// control state
	logic [4:0]                  state_q;
	logic [SW-1:0]               scan_q;
	logic [MW-1:0]               mic_q;
	logic [MAX_SOURCES-1:0]      src_valid_q;
	logic [CW-1:0]               count_q;
	logic [mads_pkg::TICK_W-1:0] tick_q;
	logic signed [CDW-1:0]       mic_x_q [NUM_MICS];
	logic signed [CDW-1:0]       mic_y_q [NUM_MICS];
	logic signed [CDW-1:0]       mic_z_q [NUM_MICS];
	logic                        out_valid_q;

	// datapath
	logic signed [CDW-1:0]         px_q;
	logic signed [CDW-1:0]         py_q;
	logic signed [CDW-1:0]         pz_q;
	logic [mads_pkg::FREQ_W-1:0]   freq_q;
	logic [1:0]                    axis_q;
	logic [33:0]                   acc_q;
	logic [mads_pkg::TRAV_W-1:0]   trav_num_q;
	logic [mads_pkg::TRAV_W-1:0]   travel_q;
	logic [mads_pkg::TICK_W-1:0]   n_q;
	logic [55:0]                   prod2_q;
	logic signed [SUMW-1:0]        sum_q;
	logic signed [mads_pkg::SAMPLE_W-1:0] res_sample_q;
	logic [mads_pkg::SEL_W-1:0]    res_mic_q;
	logic                          res_last_q;
	logic [mads_pkg::STATUS_W-1:0] res_status_q;
	logic signed [mads_pkg::SAMPLE_W-1:0] out_sample_q;
	logic [mads_pkg::SEL_W-1:0]    out_mic_q;
	logic                          out_last_q;
	logic [mads_pkg::STATUS_W-1:0] out_status_q;

	// source memory, one entry read per cycle at the scan index
	mads_pkg::src_entry_t src_mem [MAX_SOURCES];
	mads_pkg::src_entry_t rd_q;
	mads_pkg::src_entry_t mem_wdata;
	logic                 mem_we;

	assign mem_we    = (state_q == S_ADD_SCAN) && !src_valid_q[scan_q];
	assign mem_wdata = '{x: px_q, y: py_q, z: pz_q, freq: freq_q, start: tick_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			src_mem[scan_q] <= mem_wdata;
		end
		rd_q <= src_mem[scan_q];
	end

	// shared arithmetic units
	logic                            sqrt_start;
	logic [mads_pkg::SQ_OUT_W-1:0]   dist_root;
	mads_pkg::iter_stat_t            sqrt_stat;
	logic                            div_start;
	logic [mads_pkg::DIV_NW-1:0]     div_num;
	logic [mads_pkg::DIV_DW-1:0]     div_den;
	logic [mads_pkg::DIV_NW-1:0]     div_quot;
	mads_pkg::iter_stat_t            div_stat;

	assign sqrt_start = (state_q == S_SQRT_GO);

	mads_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({acc_q, 16'b0}),
		.root     (dist_root),
		.stat     (sqrt_stat)
	);

	logic [SUMW-1:0] sum_mag;
	assign sum_mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	always_comb begin
		div_start = 1'b0;
		div_num   = mads_pkg::DIV_NW'(trav_num_q);
		div_den   = mads_pkg::DIV_DW'(speed_eff);
		unique case (state_q)
			S_DIV1_GO: begin
				div_start = 1'b1;
			end
			S_DIV2_GO: begin
				div_start = 1'b1;
				div_num   = {prod2_q, 2'b00};
				div_den   = rate_eff;
			end
			S_AVG_GO: begin
				div_start = (count_q != '0);
				div_num   = mads_pkg::DIV_NW'(sum_mag);
				div_den   = mads_pkg::DIV_DW'(count_q);
			end
			default: begin
			end
		endcase
	end

	mads_divu u_divu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// combinational helpers
	logic                        accept;
	logic                        can_load;
	logic [MW-1:0]               mic_wr_idx;
	logic                        mic_in_range;
	logic signed [CDW-1:0]       mic_c;
	logic signed [CDW-1:0]       src_c;
	logic signed [CDW:0]         diff;
	logic [CDW:0]                mag;
	logic [33:0]                 sq;
	logic [42:0]                 prod1;
	logic [mads_pkg::TICK_W-1:0] elapsed;
	logic                        rm_match;
	logic                        last_src;
	logic                        last_mic;
	logic [mads_pkg::SAMPLE_W-1:0] avg_mag;

	assign req.ready    = (state_q == S_IDLE);
	assign accept       = req.valid && req.ready;
	assign can_load     = !out_valid_q || rsp.ready;
	assign mic_wr_idx   = MW'(req.mic_select);
	assign mic_in_range = (32'(req.mic_select) < NUM_MICS);
	assign last_src     = (scan_q == SW'(MAX_SOURCES - 1));
	assign last_mic     = (mic_q == MW'(NUM_MICS - 1));
	assign rm_match     = src_valid_q[scan_q] && (rd_q.x == px_q) && (rd_q.y == py_q);

	always_comb begin
		unique case (axis_q)
			2'd0: begin
				mic_c = mic_x_q[mic_q];
				src_c = rd_q.x;
			end
			2'd1: begin
				mic_c = mic_y_q[mic_q];
				src_c = rd_q.y;
			end
			default: begin
				mic_c = mic_z_q[mic_q];
				src_c = rd_q.z;
			end
		endcase
	end

	assign diff    = (CDW+1)'(mic_c) - (CDW+1)'(src_c);
	assign mag     = diff[CDW] ? (CDW+1)'(-diff) : (CDW+1)'(diff);
	assign sq      = 34'(mag) * 34'(mag);
	assign prod1   = 43'(dist_root) * 43'(rate_eff);
	assign elapsed = tick_q - rd_q.start;
	assign avg_mag = div_quot[mads_pkg::SAMPLE_W-1:0];

	// output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && can_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			mic_q       <= '0;
			src_valid_q <= '0;
			count_q     <= '0;
			tick_q      <= '0;
			for (int m = 0; m < NUM_MICS; m++) begin
				mic_x_q[m] <= '0;
				mic_y_q[m] <= '0;
				mic_z_q[m] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q <= '0;
						unique case (req.cmd)
							mads_pkg::CMD_TICK: begin
								tick_q  <= tick_q + 32'd1;
								mic_q   <= '0;
								state_q <= S_MIC_INIT;
							end
							mads_pkg::CMD_ADD: begin
								state_q <= (count_q == CW'(MAX_SOURCES)) ? S_EMIT : S_ADD_SCAN;
							end
							mads_pkg::CMD_REMOVE: begin
								state_q <= S_RM_RD;
							end
							default: begin
								if (mic_in_range) begin
									mic_x_q[mic_wr_idx] <= req.pos_x;
									mic_y_q[mic_wr_idx] <= req.pos_y;
									mic_z_q[mic_wr_idx] <= req.pos_z;
								end
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_ADD_SCAN: begin
					if (!src_valid_q[scan_q]) begin
						src_valid_q[scan_q] <= 1'b1;
						count_q <= count_q + CW'(1);
						state_q <= S_EMIT;
					end else begin
						scan_q <= scan_q + SW'(1);
					end
				end
				S_RM_RD: begin
					state_q <= S_RM_CHK;
				end
				S_RM_CHK: begin
					if (rm_match) begin
						src_valid_q[scan_q] <= 1'b0;
						count_q <= count_q - CW'(1);
						state_q <= S_EMIT;
					end else if (last_src) begin
						src_valid_q <= '0;
						count_q <= '0;
						state_q <= S_EMIT;
					end else begin
						scan_q  <= scan_q + SW'(1);
						state_q <= S_RM_RD;
					end
				end
				S_MIC_INIT: begin
					scan_q  <= '0;
					state_q <= S_SRC_RD;
				end
				S_SRC_RD: begin
					state_q <= src_valid_q[scan_q] ? S_SQ : S_NEXT;
				end
				S_SQ: begin
					if (axis_q == 2'd2) begin
						state_q <= S_SQRT_GO;
					end
				end
				S_SQRT_GO: begin
					state_q <= S_SQRT_WAIT;
				end
				S_SQRT_WAIT: begin
					if (sqrt_stat.done) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_DIV1_GO;
				end
				S_DIV1_GO: begin
					state_q <= S_DIV1_WAIT;
				end
				S_DIV1_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_PHASE;
					end
				end
				S_PHASE: begin
					state_q <= (32'(travel_q) < elapsed) ? S_MUL2 : S_NEXT;
				end
				S_MUL2: begin
					state_q <= S_DIV2_GO;
				end
				S_DIV2_GO: begin
					state_q <= S_DIV2_WAIT;
				end
				S_DIV2_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (last_src) begin
						state_q <= S_AVG_GO;
					end else begin
						scan_q  <= scan_q + SW'(1);
						state_q <= S_SRC_RD;
					end
				end
				S_AVG_GO: begin
					state_q <= (count_q == '0) ? S_EMIT : S_AVG_WAIT;
				end
				S_AVG_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							mic_q   <= mic_q + MW'(1);
							state_q <= S_MIC_INIT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && can_load) begin
			out_sample_q <= res_sample_q;
			out_mic_q    <= res_mic_q;
			out_last_q   <= res_last_q;
			out_status_q <= res_status_q;
		end
		unique case (state_q)
			S_IDLE: begin
				px_q         <= req.pos_x;
				py_q         <= req.pos_y;
				pz_q         <= req.pos_z;
				freq_q       <= req.tone_freq;
				res_sample_q <= '0;
				res_last_q   <= 1'b1;
				res_mic_q    <= (req.cmd == mads_pkg::CMD_MIC) ? req.mic_select : '0;
				res_status_q <= (req.cmd == mads_pkg::CMD_ADD && count_q == CW'(MAX_SOURCES))
					? mads_pkg::ST_FULL : mads_pkg::ST_OK;
			end
			S_RM_CHK: begin
				if (!rm_match && last_src) begin
					res_status_q <= mads_pkg::ST_NOTFOUND;
				end
			end
			S_MIC_INIT: begin
				sum_q <= '0;
			end
			S_SRC_RD: begin
				axis_q <= 2'd0;
				acc_q  <= '0;
			end
			S_SQ: begin
				acc_q  <= acc_q + sq;
				axis_q <= axis_q + 2'd1;
			end
			S_MUL1: begin
				trav_num_q <= prod1[42:16];
			end
			S_DIV1_WAIT: begin
				if (div_stat.done) begin
					travel_q <= div_quot[mads_pkg::TRAV_W-1:0];
				end
			end
			S_PHASE: begin
				n_q <= elapsed - 32'(travel_q);
			end
			S_MUL2: begin
				prod2_q <= 56'(rd_q.freq) * 56'(n_q);
			end
			S_DIV2_WAIT: begin
				if (div_stat.done) begin
					sum_q <= sum_q + SUMW'(mads_pkg::sine_value(div_quot[9:0]));
				end
			end
			S_AVG_GO: begin
				res_sample_q <= '0;
				res_mic_q    <= mads_pkg::SEL_W'(mic_q);
				res_last_q   <= last_mic;
				res_status_q <= mads_pkg::ST_OK;
			end
			S_AVG_WAIT: begin
				if (div_stat.done) begin
					res_sample_q <= sum_q[SUMW-1] ? -signed'(avg_mag) : signed'(avg_mag);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.mic_sample = out_sample_q;
	assign rsp.mic_number = out_mic_q;
	assign rsp.last       = out_last_q;
	assign rsp.status     = out_status_q;

	`MADS_ASSERT_SAME(a_count_tracks_valid, 1'b1, $countones(src_valid_q) == 32'(count_q), "source count out of step with valid bits")
	`MADS_ASSERT_SAME(a_sqrt_start_idle, sqrt_start, !sqrt_stat.busy, "root unit restarted while busy")
	`MADS_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
	`MADS_ASSERT_NEXT(a_emit_holds, (state_q == S_EMIT) && out_valid_q && !rsp.ready, state_q == S_EMIT, "result dropped while output register full")
endmodule
